@@ rtl/core/cll_pkg.sv @@
// ----------------------------------------------------------------------------
// cll_pkg
// Request codes, status codes and controller types for the cursor list engine.
// ----------------------------------------------------------------------------
`default_nettype none
package cll_pkg;

  typedef enum logic [3:0] {
    REQ_FIRST      = 4'd0,
    REQ_NEXT       = 4'd1,
    REQ_LAST       = 4'd2,
    REQ_PREV       = 4'd3,
    REQ_PUSH_FRONT = 4'd4,
    REQ_PUSH_BACK  = 4'd5,
    REQ_INSERT     = 4'd6,
    REQ_POP_FRONT  = 4'd7,
    REQ_POP_BACK   = 4'd8,
    REQ_POP_CURSOR = 4'd9,
    REQ_CLEAR      = 4'd10
  } req_e;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNothing = 2'd1;
  localparam logic [1:0] StatusFull    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_EXEC,
    ST_OUT
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;  // latch the request
    logic rd;       // issue memory reads for the request
    logic exec;     // apply link writes and pointer updates, form the result
    logic out_take; // result taken downstream
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic out_valid;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/core/cll_ctrl.sv @@
// ----------------------------------------------------------------------------
// cll_ctrl
// Sequencer: capture, read links, execute, hold the result until taken.
// ----------------------------------------------------------------------------
`default_nettype none
module cll_ctrl
  import cll_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic out_ready_i,
  output cmd_t      cmd_o,
  input  wire sts_t sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d = ST_WAIT;
      end
      ST_WAIT: state_d = ST_EXEC;
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          cmd_o.out_take = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  property p_result_in_out;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == ST_OUT) |-> sts_i.out_valid;
  endproperty
  a_result_in_out: assert property (p_result_in_out) else $error("result missing");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o) else $error("ready while busy");

  a_exec_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> (state_q == ST_OUT)) else $error("exec not followed by out");

endmodule
`default_nettype wire

@@ rtl/core/cll_dp.sv @@
// ----------------------------------------------------------------------------
// cll_dp
// Pointer registers, node pool memories and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module cll_dp
  import cll_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [3:0]            req_type_i,
  input  wire logic [31:0]           data_in_i,
  input  wire cmd_t                  cmd_i,
  output sts_t                       sts_o,
  output logic [31:0]                data_out_o,
  output logic                       found_o,
  output logic [1:0]                 status_o
);

  localparam int unsigned AW = $clog2(POOL_DEPTH);
  localparam int unsigned PW = $clog2(POOL_DEPTH + 1);
  localparam logic [PW-1:0] Nil = PW'(POOL_DEPTH);

  logic [PW-1:0] next_mem [POOL_DEPTH];
  logic [PW-1:0] prev_mem [POOL_DEPTH];
  logic [DATA_WIDTH-1:0] pay_mem [POOL_DEPTH];

  logic [PW-1:0] head_q, tail_q, cur_q, free_q, fresh_q;
  logic [3:0] req_q;
  logic [DATA_WIDTH-1:0] word_q;

  // Read data from the first read cycle
  logic [PW-1:0] cur_nx_q, cur_pv_q, free_nx_q;
  logic [DATA_WIDTH-1:0] rd_pay_q;

  logic [31:0] dout_q;
  logic found_q, ov_q;
  logic [1:0] stat_q;

  function automatic logic ok(input logic [PW-1:0] p);
    return p < Nil;
  endfunction

  // Node whose payload is read: move target or popped node
  logic [PW-1:0] pay_sel, pop_node;
  always_comb begin
    pop_node = cur_q;
    case (req_e'(req_q))
      REQ_POP_FRONT: pop_node = head_q;
      REQ_POP_BACK:  pop_node = tail_q;
      default:       pop_node = cur_q;
    endcase
  end

  // Read stage: links of the request's node (tail for push back) and of the
  // free head; payload of the move target
  logic [PW-1:0] rd_c;
  always_comb begin
    rd_c = (req_e'(req_q) == REQ_PUSH_BACK) ? tail_q : pop_node;
    case (req_e'(req_q))
      REQ_FIRST: pay_sel = head_q;
      REQ_LAST:  pay_sel = tail_q;
      REQ_NEXT, REQ_PREV: pay_sel = cur_q; // second read happens in wait
      default:   pay_sel = pop_node;
    endcase
  end

  // Memory read ports, registered. Cycle rd: node links; wait: target payload.
  logic rd2_q;
  logic [PW-1:0] tgt;
  always_comb begin
    tgt = (req_e'(req_q) == REQ_NEXT) ? cur_nx_q : cur_pv_q;
    if (!ok(cur_q)) tgt = Nil;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      if (ok(rd_c)) begin
        cur_nx_q <= next_mem[rd_c[AW-1:0]];
        cur_pv_q <= prev_mem[rd_c[AW-1:0]];
      end else begin
        cur_nx_q <= Nil;
        cur_pv_q <= Nil;
      end
      free_nx_q <= ok(free_q) ? next_mem[free_q[AW-1:0]] : Nil;
      rd_pay_q  <= ok(pay_sel) ? pay_mem[pay_sel[AW-1:0]] : '0;
    end
    if (rd2_q && (req_e'(req_q) == REQ_NEXT || req_e'(req_q) == REQ_PREV)) begin
      rd_pay_q <= ok(tgt) ? pay_mem[tgt[AW-1:0]] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd2_q <= 1'b0;
    else rd2_q <= cmd_i.rd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      word_q <= DATA_WIDTH'(data_in_i);
    end
  end

  // Execute: compute all writes (at most two link writes per memory)
  logic [PW-1:0] head_d, tail_d, cur_d, free_d, fresh_d;
  logic [31:0] dout_d;
  logic found_d;
  logic [1:0] stat_d;
  logic nw1, nw2, pw1, pw2, payw;
  logic [PW-1:0] na1, nd1, na2, nd2, pa1, pd1, pa2, pd2, newn, c, after;

  always_comb begin
    head_d = head_q; tail_d = tail_q; cur_d = cur_q; free_d = free_q; fresh_d = fresh_q;
    dout_d = '0; found_d = 1'b0; stat_d = StatusOk;
    nw1 = 1'b0; nw2 = 1'b0; pw1 = 1'b0; pw2 = 1'b0; payw = 1'b0;
    na1 = '0; nd1 = '0; na2 = '0; nd2 = '0; pa1 = '0; pd1 = '0; pa2 = '0; pd2 = '0;
    newn = Nil; c = Nil; after = Nil;
    case (req_e'(req_q))
      REQ_FIRST, REQ_NEXT, REQ_LAST, REQ_PREV: begin
        case (req_e'(req_q))
          REQ_FIRST: c = head_q;
          REQ_LAST:  c = tail_q;
          default:   c = tgt;
        endcase
        if (ok(c)) begin
          cur_d = c; found_d = 1'b1; dout_d = 32'(rd_pay_q);
        end else begin
          stat_d = StatusNothing;
        end
      end
      REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
        if (ok(free_q)) begin
          newn = free_q; free_d = free_nx_q;
        end else if (fresh_q < Nil) begin
          newn = fresh_q; fresh_d = fresh_q + 1'b1;
        end
        if (!ok(newn)) begin
          stat_d = StatusFull;
          free_d = free_q; fresh_d = fresh_q;
        end else begin
          payw = 1'b1;
          c = Nil;
          after = Nil;
          if (req_e'(req_q) == REQ_INSERT && ok(cur_q)) begin
            c = cur_q; after = cur_nx_q;
          end else if (req_e'(req_q) == REQ_PUSH_BACK) begin
            cur_d = tail_q;
            if (ok(tail_q)) begin
              c = tail_q; after = cur_nx_q;
            end
          end
          if (ok(c)) begin
            nw1 = 1'b1; na1 = newn; nd1 = after;
            pw1 = 1'b1; pa1 = newn; pd1 = c;
            if (ok(after)) begin
              pw2 = 1'b1; pa2 = after; pd2 = newn;
            end else begin
              tail_d = newn;
            end
            nw2 = 1'b1; na2 = c; nd2 = newn;
          end else begin
            pw1 = 1'b1; pa1 = newn; pd1 = Nil;
            nw1 = 1'b1; na1 = newn; nd1 = head_q;
            if (!ok(head_q)) begin
              head_d = newn; tail_d = newn;
            end else begin
              pw2 = 1'b1; pa2 = head_q; pd2 = newn;
              head_d = newn;
            end
          end
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK, REQ_POP_CURSOR: begin
        cur_d = pop_node;
        if (ok(pop_node)) begin
          found_d = 1'b1;
          dout_d = 32'(rd_pay_q);
          if (ok(cur_pv_q)) begin
            nw1 = 1'b1; na1 = cur_pv_q; nd1 = cur_nx_q;
          end else begin
            head_d = cur_nx_q;
          end
          if (ok(cur_nx_q)) begin
            pw1 = 1'b1; pa1 = cur_nx_q; pd1 = cur_pv_q;
          end else begin
            tail_d = cur_pv_q;
          end
          cur_d = cur_nx_q;
          nw2 = 1'b1; na2 = pop_node; nd2 = free_q;
          free_d = pop_node;
        end else begin
          stat_d = StatusNothing;
        end
      end
      REQ_CLEAR: begin
        if (ok(head_q)) begin
          nw1 = 1'b1; na1 = tail_q; nd1 = free_q;
          free_d = head_q;
        end
        head_d = Nil; tail_d = Nil; cur_d = Nil;
      end
      default: ;
    endcase
  end

  // Writes land in the exec cycle; write 2 follows write 1 so a later write wins.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (nw1) next_mem[na1[AW-1:0]] <= nd1;
      if (nw2) next_mem[na2[AW-1:0]] <= nd2;
      if (pw1) prev_mem[pa1[AW-1:0]] <= pd1;
      if (pw2) prev_mem[pa2[AW-1:0]] <= pd2;
      if (payw) pay_mem[newn[AW-1:0]] <= word_q;
      dout_q <= dout_d;
      found_q <= found_d;
      stat_q <= stat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= Nil; tail_q <= Nil; cur_q <= Nil; free_q <= Nil;
      fresh_q <= '0; ov_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        head_q <= head_d; tail_q <= tail_d; cur_q <= cur_d;
        free_q <= free_d; fresh_q <= fresh_d;
        ov_q <= 1'b1;
      end else if (cmd_i.out_take) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_valid = ov_q;
  assign data_out_o = dout_q;
  assign found_o    = found_q;
  assign status_o   = stat_q;

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && found_q) |-> (stat_q == StatusOk)) else $error("found with bad status");
  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= Nil) else $error("fresh count overflow");
  a_head_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == Nil) == (tail_q == Nil)) else $error("head and tail disagree");

endmodule
`default_nettype wire

@@ rtl/core/cursor_linked_list_engine_top.sv @@
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_top
// Doubly linked list with cursor in a fixed node pool.
// ----------------------------------------------------------------------------
// Each request passes through the accepting cycle, a link read of the pool
// memories, a second read cycle that fetches the payload of a next/prev
// target, the execute cycle that writes neighbor links and pointers, and the
// cycle that presents the result. The result becomes valid as the execute
// cycle ends and is held until taken, so a stalled receiver adds its stall to
// the item time. One request is in flight at a time; the dependent pool
// memory reads and writes set the rate. Nodes come from a recycled chain first,
// then from never-used pool entries, so no clearing pass follows reset.
`default_nettype none
module cursor_linked_list_engine_top
  import cll_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  req_type_i,
  input  wire logic [31:0] data_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      data_out_o,
  output logic             found_o,
  output logic [1:0]       status_o
);

  cmd_t cmd;
  sts_t sts;

  cll_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  cll_dp #(.POOL_DEPTH(POOL_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk_i, .rst_ni,
    .req_type_i, .data_in_i,
    .cmd_i(cmd), .sts_o(sts),
    .data_out_o, .found_o, .status_o
  );

  assign out_valid_o = sts.out_valid;

endmodule
`default_nettype wire
